// ===== hw/rtl/cwmf_pkg.sv =====
// Shared types and constants for the clipped-window median filter.
// No dependencies.
package cwmf_pkg;
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_INSERT,
      ST_PICK,
      ST_SHOW
   } state_type;
endpackage

// ===== hw/rtl/cwmf_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module cwmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== hw/rtl/cwmf_sorter.sv =====
// Insertion sorter: a row of cells that keeps pixels in ascending order.
// No dependencies; cwmf_pkg is not imported.
module cwmf_sorter #(
   parameter int DEPTH = 49
) (
   input  logic                     clock,
   input  logic                     clear,
   input  logic                     insert,
   input  logic [7:0]               value,
   input  logic [$clog2(DEPTH)-1:0] pick,
   output logic [7:0]               picked
);
   logic [7:0] cell_ff [DEPTH];
   logic [7:0] cell_in [DEPTH];
   logic [DEPTH-1:0] used_ff, used_in;
   logic [DEPTH-1:0] big;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         big[i] = !used_ff[i] || (cell_ff[i] > value);
      end
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
         if (big[i]) begin
            if (i == 0) begin
               cell_in[i] = value;
            end else if (big[i-1]) begin
               cell_in[i] = cell_ff[i-1];
            end else begin
               cell_in[i] = value;
            end
         end
      end
      used_in = {used_ff[DEPTH-2:0], 1'b1};
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         used_ff <= '0;
      end else if (insert) begin
         used_ff <= used_in;
      end
      if (insert) begin
         for (int i = 0; i < DEPTH; i++) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   end

   assign picked = cell_ff[pick];
endmodule

// ===== hw/rtl/clipped_window_median_filter.sv =====
// Clipped-window median filter over a frame store in one synchronous RAM.
// Load: written at its accept edge, one load per cycle back to back while the block is idle.
// Query: READ walks the window, in-image positions pass WAIT and INSERT; then PICK, SHOW.
// A bad channel goes straight to SHOW. No item is taken while a query runs. A stalled
// result waits in its own register; reset (synchronous, active high) restores state, valid
// and CSR registers, not the frame store. Depends on cwmf_pkg, cwmf_ram, cwmf_sorter.
module clipped_window_median_filter
   import cwmf_pkg::*;
#(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int NUM_CHANNELS = 3,
   parameter int MAX_RADIUS   = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,    // operation
   input  logic [31:0] req_tdata,    // column[7:0], row_index[15:8], channel[17:16],
                                     // pixel_value[25:18], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // median_value[7:0], pixel_count[13:8], zero fill
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wr_data
);
   localparam int WIN_SIDE = 2 * MAX_RADIUS + 1;
   localparam int WIN_MAX  = WIN_SIDE * WIN_SIDE;
   localparam int XW       = $clog2(MAX_WIDTH)  > 0 ? $clog2(MAX_WIDTH)  : 1;
   localparam int YW       = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW       = $clog2(NUM_CHANNELS) > 0 ? $clog2(NUM_CHANNELS) : 1;
   localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT * NUM_CHANNELS;
   localparam int AW       = $clog2(DEPTH);
   localparam int RW       = $clog2(MAX_RADIUS + 1);
   localparam int PW       = $clog2(WIN_MAX);
   localparam int CNTW     = $clog2(WIN_MAX + 1);

   // payload unpack
   logic [7:0] col, row;
   logic [1:0] chn;
   logic [7:0] pix;
   assign col = req_tdata[7:0];
   assign row = req_tdata[15:8];
   assign chn = req_tdata[17:16];
   assign pix = req_tdata[25:18];

   // configuration registers
   logic [8:0] width_ff, height_ff;
   logic [1:0] radius_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         radius_ff <= 2'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wr_data;
            CSR_HEIGHT: height_ff <= csr_wr_data;
            CSR_RADIUS: radius_ff <= csr_wr_data[1:0];
            default: ;
         endcase
      end
   end

   // clamp to store limits
   logic [12:0] w_eff, h_eff;
   logic [RW-1:0] r_eff;
   assign w_eff = ({4'd0, width_ff}  > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : {4'd0, width_ff};
   assign h_eff = ({4'd0, height_ff} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, height_ff};
   assign r_eff = (32'(radius_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_ff);

   // item registers
   state_type state_ff, state_in;
   logic [7:0] col_ff, row_ff;
   logic [CW-1:0] ch_ff;
   logic [RW-1:0] r_ff;
   logic [4:0] dx_ff, dx_in, dy_ff, dy_in; // offset 0..2r
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic pass_ff;                          // radius zero
   logic [7:0] med_ff, med_in;
   logic [5:0] pcnt_ff, pcnt_in;
   logic valid_ff, valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;  // result held for the downstream side

   // window position (signed math, 14 bits)
   logic signed [13:0] wx, wy;
   logic in_image, last_pos;
   assign wx = $signed({6'd0, col_ff}) + $signed({9'd0, dx_ff}) - $signed({12'd0, r_ff});
   assign wy = $signed({6'd0, row_ff}) + $signed({9'd0, dy_ff}) - $signed({12'd0, r_ff});
   assign in_image = pass_ff ? 1'b1 :
      (wx >= 0 && wy >= 0 && wx < $signed({1'b0, w_eff}) && wy < $signed({1'b0, h_eff}));
   assign last_pos = (dx_ff == 5'({r_ff, 1'b0})) && (dy_ff == 5'({r_ff, 1'b0}));

   logic accept, bad_ch, in_store;
   assign accept   = req_tvalid && req_tready;
   assign bad_ch   = 32'(chn) >= NUM_CHANNELS;
   assign in_store = 32'(col) < MAX_WIDTH && 32'(row) < MAX_HEIGHT;

   // memory port
   logic ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0] ram_q;
   logic [XW-1:0] ax;
   logic [YW-1:0] ay;
   always_comb begin
      ax = XW'(wx);
      ay = YW'(wy);
      if (state_ff == ST_IDLE) begin
         ax = XW'(col);
         ay = YW'(row);
      end
   end
   logic [AW+1:0] addr_full;
   assign addr_full = (AW+2)'(((state_ff == ST_IDLE ? 32'(chn) : 32'(ch_ff)) * MAX_HEIGHT
                      + 32'(ay)) * MAX_WIDTH + 32'(ax));
   assign ram_addr = addr_full[AW-1:0];
   assign ram_we   = accept && req_tuser == OP_LOAD && !bad_ch && in_store;

   cwmf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(pix), .rd_data(ram_q)
   );

   logic sort_clear, sort_ins;
   logic [PW-1:0] pick;
   logic [7:0] picked;
   assign pick = PW'(cnt_ff >> 1);
   cwmf_sorter #(.DEPTH(WIN_MAX)) u_sort (
      .clock(clock), .clear(sort_clear), .insert(sort_ins), .value(ram_q),
      .pick(pick), .picked(picked)
   );

   // Accept in idle; a waiting result sits in its own register and does not block.
   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in    = state_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      cnt_in      = cnt_ff;
      med_in      = med_ff;
      pcnt_in     = pcnt_ff;
      valid_in    = valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      sort_clear  = 1'b0;
      sort_ins    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser == OP_QUERY) begin
               dx_in = '0;
               dy_in = '0;
               cnt_in = '0;
               sort_clear = 1'b1;
               if (bad_ch || (r_eff == '0 && !in_store)) begin
                  med_in = '0;
                  pcnt_in = '0;
                  state_in = ST_SHOW;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // address driven from window position; skip outside positions
            if (in_image) begin
               state_in = ST_WAIT;
            end else if (last_pos) begin
               state_in = ST_PICK;
            end else if (dy_ff == 5'({r_ff, 1'b0})) begin
               dy_in = '0;
               dx_in = dx_ff + 5'd1;
            end else begin
               dy_in = dy_ff + 5'd1;
            end
         end
         ST_WAIT: begin
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            sort_ins = 1'b1;
            cnt_in = cnt_ff + CNTW'(1);
            if (last_pos) begin
               state_in = ST_PICK;
            end else begin
               state_in = ST_READ;
               if (dy_ff == 5'({r_ff, 1'b0})) begin
                  dy_in = '0;
                  dx_in = dx_ff + 5'd1;
               end else begin
                  dy_in = dy_ff + 5'd1;
               end
            end
         end
         ST_PICK: begin
            med_in  = (cnt_ff == '0) ? 8'd0 : picked;
            pcnt_in = 6'(cnt_ff);
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            // hold until the result register is free or drains this cycle
            if (!valid_ff || rsp_tready) begin
               valid_in    = 1'b1;
               rsp_data_in = {2'd0, pcnt_ff, med_ff};
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      cnt_ff      <= cnt_in;
      med_ff      <= med_in;
      pcnt_ff     <= pcnt_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         col_ff  <= col;
         row_ff  <= row;
         ch_ff   <= CW'(chn);
         r_ff    <= r_eff;
         pass_ff <= r_eff == '0;
      end
   end
endmodule

// ===== tb/clipped_window_median_filter_test.sv =====
// Self-checking testbench for the clipped-window median filter: loads and queries
// driven over the stream ports, results checked against an in-bench window median.
// Depends on cwmf_pkg and clipped_window_median_filter.
module clipped_window_median_filter_test;
   import cwmf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_W     = 256;
   localparam int STORE_H     = 256;
   localparam int CHANNELS    = 3;
   localparam int STORE_DEPTH = STORE_W * STORE_H * CHANNELS;
   localparam int SETTLE      = 150;       // longer than the slowest query
   localparam int CYCLE_LIMIT = 3000000;
   localparam int PHASE_ITEMS = 250;

   typedef struct packed {
      logic [7:0] median;
      logic [5:0] count;
   } median_result_type;

   // Frame store mirror, register copy and queue of pending window medians.
   class median_scoreboard;
      bit [7:0]          frame [0:STORE_DEPTH-1];
      bit                written [0:STORE_DEPTH-1];
      int unsigned       img_w, img_h, radius;
      median_result_type pending[$];
      int                mismatches;

      function new();
         img_w  = 256;
         img_h  = 256;
         radius = 1;
      endfunction

      function int addr(int x, int y, int ch);
         return (ch * STORE_H + y) * STORE_W + x;
      endfunction

      function void set_reg(logic [1:0] idx, logic [8:0] value);
         case (idx)
            CSR_WIDTH:  img_w  = 32'(value);
            CSR_HEIGHT: img_h  = 32'(value);
            CSR_RADIUS: radius = 32'(value[1:0]);
            default: ;
         endcase
      endfunction

      function median_result_type window_median(int col, int row, int ch);
         bit [7:0]          win [0:48];
         bit [7:0]          v;
         int                cnt, w, h, x, y, k, r;
         median_result_type res;
         res = '0;
         cnt = 0;
         w = img_w > STORE_W ? STORE_W : img_w;
         h = img_h > STORE_H ? STORE_H : img_h;
         r = radius;
         if (ch < CHANNELS) begin
            if (r == 0) begin
               res.median = frame[addr(col, row, ch)];
               res.count  = 6'd1;
            end else begin
               for (int dx = -r; dx <= r; dx++) begin
                  for (int dy = -r; dy <= r; dy++) begin
                     x = col + dx;
                     y = row + dy;
                     if (x < 0 || y < 0 || x >= w || y >= h) continue;
                     v = frame[addr(x, y, ch)];
                     k = cnt;
                     while (k > 0 && win[k-1] > v) begin
                        win[k] = win[k-1];
                        k--;
                     end
                     win[k] = v;
                     cnt++;
                  end
               end
               if (cnt > 0) res.median = win[cnt/2];
               res.count = cnt[5:0];
            end
         end
         return res;
      endfunction

      function void note_item(logic op, logic [7:0] col, logic [7:0] row,
                              logic [1:0] ch, logic [7:0] pix);
         if (op == OP_LOAD) begin
            if (ch < CHANNELS) begin
               frame[addr(col, row, ch)]   = pix;
               written[addr(col, row, ch)] = 1'b1;
            end
         end else begin
            pending.push_back(window_median(col, row, ch));
         end
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
         mismatches++;
      endtask

      task check_result(logic [15:0] data);
         median_result_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result, median", data[7:0], -1);
         end else begin
            want = pending.pop_front();
            if (data[7:0] !== want.median) report_mismatch("median", data[7:0], want.median);
            if (data[13:8] !== want.count) report_mismatch("count", data[13:8], want.count);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [8:0]  csr_wr_data = '0;

   median_scoreboard sb = new();
   int  cycles;
   int  items_sent;
   int  rsp_hold;       // long receiver hold-off, counted down by the receiver
   bit  no_gaps;        // stretches without any idling

   clipped_window_median_filter uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones.
   function int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (no_gaps || sel < 50) return 0;
      if (sel < 88) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: check each accepted item, then pick the next tready.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Offer one item and hold it until accepted; keep tvalid high across back-to-back items.
   task send_item(logic op, logic [7:0] col, logic [7:0] row, logic [1:0] ch,
                  logic [7:0] pix);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, pix, ch, row, col};
      do @(posedge clock); while (!req_tready);
      sb.note_item(op, col, row, ch, pix);
      items_sent++;
   endtask

   // Drop tvalid, wait for every pending result, then let a trailing load finish.
   task wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_reg(logic [1:0] idx, logic [8:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   task configure(int w, int h, int r);
      wait_drained();
      write_reg(CSR_WIDTH, w[8:0]);
      write_reg(CSR_HEIGHT, h[8:0]);
      write_reg(CSR_RADIUS, r[8:0]);
      @(posedge clock);
   endtask

   // Load every in-image window pixel not yet written, then issue the query.
   task query_pixel(int col, int row, int ch);
      int w, h, x, y, r;
      w = sb.img_w > STORE_W ? STORE_W : sb.img_w;
      h = sb.img_h > STORE_H ? STORE_H : sb.img_h;
      r = sb.radius;
      if (ch < CHANNELS) begin
         if (r == 0) begin
            if (!sb.written[sb.addr(col, row, ch)])
               send_item(OP_LOAD, col[7:0], row[7:0], ch[1:0], 8'($urandom));
         end else begin
            for (int dx = -r; dx <= r; dx++) begin
               for (int dy = -r; dy <= r; dy++) begin
                  x = col + dx;
                  y = row + dy;
                  if (x < 0 || y < 0 || x >= w || y >= h) continue;
                  if (!sb.written[sb.addr(x, y, ch)])
                     send_item(OP_LOAD, x[7:0], y[7:0], ch[1:0], 8'($urandom));
               end
            end
         end
      end
      send_item(OP_QUERY, col[7:0], row[7:0], ch[1:0], 8'($urandom));
   endtask

   // Positions cluster near the image edges so windows get clipped and reused.
   function int pick_coord(int lim);
      int eff, sel, hi;
      eff = lim > STORE_W ? STORE_W : lim;
      sel = $urandom_range(0, 9);
      if (eff <= 24) begin
         hi = eff + 3;
         return $urandom_range(0, hi);
      end
      if (sel < 4) return $urandom_range(0, 15);
      if (sel < 8) begin
         hi = eff + 3 > 255 ? 255 : eff + 3;
         return $urandom_range(eff - 16, hi);
      end
      return $urandom_range(0, 255);
   endfunction

   task random_item();
      int sel, col, row;
      sel = $urandom_range(0, 99);
      col = pick_coord(sb.img_w);
      row = pick_coord(sb.img_h);
      if (sel < 30)
         send_item(OP_LOAD, col[7:0], row[7:0], 2'($urandom_range(0, 2)), 8'($urandom));
      else if (sel < 35)
         send_item(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 2'd3,
                   8'($urandom));
      else
         query_pixel(col, row, $urandom_range(0, 2));
   endtask

   initial begin
      int phase_w [8] = '{256, 1, 511, 7, 300, 16, 2, 33};
      int phase_h [8] = '{256, 1, 511, 9, 20, 16, 256, 5};
      int phase_r [8] = '{3, 2, 1, 3, 2, 0, 3, 1};
      int stop_at;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme pixels and corners with reset registers (256x256, radius 1).
      send_item(OP_LOAD, 8'd0, 8'd0, 2'd0, 8'd0);
      send_item(OP_LOAD, 8'd1, 8'd0, 2'd0, 8'd255);
      send_item(OP_LOAD, 8'd0, 8'd1, 2'd0, 8'd128);
      send_item(OP_LOAD, 8'd1, 8'd1, 2'd0, 8'd7);
      query_pixel(0, 0, 0);
      send_item(OP_LOAD, 8'd255, 8'd255, 2'd2, 8'd255);
      send_item(OP_LOAD, 8'd254, 8'd254, 2'd2, 8'd0);
      query_pixel(255, 255, 2);
      query_pixel(128, 77, 1);
      send_item(OP_LOAD, 8'd5, 8'd5, 2'd3, 8'hAA);    // bad channel: dropped
      send_item(OP_QUERY, 8'd5, 8'd5, 2'd3, 8'h00);   // bad channel: empty answer
      // Radius zero passes the stored pixel through.
      configure(256, 256, 0);
      query_pixel(255, 255, 2);
      query_pixel(0, 1, 0);
      // Empty image: no in-image window pixel.
      configure(0, 0, 1);
      send_item(OP_QUERY, 8'd0, 8'd0, 2'd0, 8'h00);
      send_item(OP_QUERY, 8'd200, 8'd3, 2'd1, 8'hFF);
      // Radius zero ignores the image size.
      configure(0, 0, 0);
      query_pixel(1, 0, 0);
      // Single-pixel image with full radius; load outside the image still lands.
      configure(1, 1, 3);
      send_item(OP_LOAD, 8'd2, 8'd0, 2'd1, 8'd99);
      query_pixel(0, 0, 1);
      query_pixel(3, 2, 1);

      // Random phases over several image and window settings.
      for (int p = 0; p < 8; p++) begin
         configure(phase_w[p], phase_h[p], phase_r[p]);
         no_gaps = (p == 4);
         // Hold the receiver off so the block fills and stalls its input.
         if (p == 2) rsp_hold = 600;
         stop_at = items_sent + PHASE_ITEMS;
         while (items_sent < stop_at) random_item();
         // Pause the sender until every result is back.
         if (p == 5) wait_drained();
      end

      wait_drained();
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
